// File: hw/rtl/pots_pkg.sv
package pots_pkg;

   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 32;
   localparam int FRAC_BITS  = 8;
   localparam int MEAN_BITS  = TIME_BITS + FRAC_BITS;

   localparam int NOW_PORT_W   = 32;
   localparam int MEAN_PORT_W  = 40;
   localparam int COUNT_PORT_W = 32;

   localparam int STATE_NUM  = 4;
   localparam int PAIR_NUM   = STATE_NUM * STATE_NUM;
   localparam int DIV_CNT_W  = $clog2(MEAN_BITS);

   typedef logic [1:0]            occ_type;
   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [MEAN_BITS-1:0]  mean_type;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == '1) ? v : v + count_type'(1);
   endfunction

endpackage

// File: hw/rtl/pair_occupancy_transition_stats_core.sv
// Occupancy transition statistics for a pair of programs.
// Input channel (req_*): one transaction per event, carrying the current time in
// seconds and the running flags of programs A and B. req_stall is high while an
// event is being processed, so events are taken one at a time.
// Result channel (rsp_*): exactly one transaction per event. An event whose time
// equals the last change time, or whose state equals the stored state, only
// reports the current state. Otherwise the result gives the state left, its
// updated mean dwell (32.8 fixed point), its departure count and the count of
// this particular transition; all counts saturate.
// Steps: an ignored event goes from the check state straight to the result; a
// transition passes through the difference state, the one-bit-per-cycle restoring
// divider that divides the mean correction by the departure count, and a finish
// state before its result is presented.
// A new event is taken the cycle after the result transaction completes.
// When the receiver stalls, the result holds and no new event is accepted.
// Synchronous reset clears the state to neither running, the last change time to
// zero and all means and counts to zero.
module pair_occupancy_transition_stats_core
   import pots_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NOW_PORT_W-1:0]   req_now,
   input  logic                    req_a_running,
   input  logic                    req_b_running,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_changed,
   output logic [1:0]              rsp_current_state,
   output logic [1:0]              rsp_left_state,
   output logic [MEAN_PORT_W-1:0]  rsp_left_mean_dwell,
   output logic [COUNT_PORT_W-1:0] rsp_left_visits,
   output logic [COUNT_PORT_W-1:0] rsp_transition_count
);

   logic [2:0]           state_ff, state_in;
   time_type             now_ff, now_in;
   occ_type              new_ff, new_in;
   occ_type              occ_ff, occ_in;
   time_type             last_ff, last_in;
   mean_type             mean_ff [STATE_NUM];
   mean_type             mean_in [STATE_NUM];
   count_type            cnt_ff [PAIR_NUM];
   count_type            cnt_in [PAIR_NUM];
   mean_type             dfx_ff, dfx_in;
   count_type            n_ff, n_in;
   count_type            trans_ff, trans_in;
   logic                 ge_ff, ge_in;
   mean_type             num_ff, num_in;
   count_type            rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] bit_ff, bit_in;

   logic                 out_changed_ff, out_changed_in;
   occ_type              out_cur_ff, out_cur_in;
   occ_type              out_left_ff, out_left_in;
   mean_type             out_mean_ff, out_mean_in;
   count_type            out_visits_ff, out_visits_in;
   count_type            out_trans_ff, out_trans_in;

   logic [3:0]           cnt_idx;
   count_type            cnt_rd;
   count_type            cnt_next;
   mean_type             mean_cur;
   time_type             dwell;
   logic [COUNT_BITS:0]  rem_shift;
   logic [COUNT_BITS:0]  rem_diff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   assign rsp_changed          = out_changed_ff;
   assign rsp_current_state    = out_cur_ff;
   assign rsp_left_state       = out_left_ff;
   assign rsp_left_mean_dwell  = MEAN_PORT_W'(out_mean_ff);
   assign rsp_left_visits      = COUNT_PORT_W'(out_visits_ff);
   assign rsp_transition_count = COUNT_PORT_W'(out_trans_ff);

   assign cnt_idx   = (state_ff == ST_CHECK) ? {occ_ff, occ_ff} : {occ_ff, new_ff};
   assign cnt_rd    = cnt_ff[cnt_idx];
   assign cnt_next  = sat_inc(cnt_rd);
   assign mean_cur  = mean_ff[occ_ff];
   assign dwell     = (now_ff >= last_ff) ? now_ff - last_ff : '0;
   assign rem_shift = {rem_ff, num_ff[MEAN_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, n_ff};

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      new_in         = new_ff;
      occ_in         = occ_ff;
      last_in        = last_ff;
      mean_in        = mean_ff;
      cnt_in         = cnt_ff;
      dfx_in         = dfx_ff;
      n_in           = n_ff;
      trans_in       = trans_ff;
      ge_in          = ge_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      bit_in         = bit_ff;
      out_changed_in = out_changed_ff;
      out_cur_in     = out_cur_ff;
      out_left_in    = out_left_ff;
      out_mean_in    = out_mean_ff;
      out_visits_in  = out_visits_ff;
      out_trans_in   = out_trans_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = TIME_BITS'(req_now);
               new_in   = {req_b_running, req_a_running};
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((now_ff == last_ff) || (new_ff == occ_ff)) begin
               out_changed_in = 1'b0;
               out_cur_in     = occ_ff;
               out_left_in    = '0;
               out_mean_in    = '0;
               out_visits_in  = '0;
               out_trans_in   = '0;
               state_in       = ST_OUT;
            end else begin
               dfx_in          = mean_type'(dwell) << FRAC_BITS;
               n_in            = cnt_next;
               cnt_in[cnt_idx] = cnt_next;
               state_in        = ST_DIFF;
            end
         end
         ST_DIFF: begin
            ge_in           = (dfx_ff >= mean_cur);
            num_in          = (dfx_ff >= mean_cur) ? dfx_ff - mean_cur : mean_cur - dfx_ff;
            trans_in        = cnt_next;
            cnt_in[cnt_idx] = cnt_next;
            rem_in          = '0;
            bit_in          = DIV_CNT_W'(MEAN_BITS - 1);
            state_in        = ST_DIV;
         end
         ST_DIV: begin
            if (!rem_diff[COUNT_BITS]) begin
               rem_in = rem_diff[COUNT_BITS-1:0];
               num_in = {num_ff[MEAN_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[COUNT_BITS-1:0];
               num_in = {num_ff[MEAN_BITS-2:0], 1'b0};
            end
            bit_in = bit_ff - DIV_CNT_W'(1);
            if (bit_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            mean_in[occ_ff] = ge_ff ? mean_cur + num_ff : mean_cur - num_ff;
            out_changed_in  = 1'b1;
            out_cur_in      = new_ff;
            out_left_in     = occ_ff;
            out_mean_in     = ge_ff ? mean_cur + num_ff : mean_cur - num_ff;
            out_visits_in   = n_ff;
            out_trans_in    = trans_ff;
            occ_in          = new_ff;
            last_in         = now_ff;
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         last_ff  <= '0;
         for (int i = 0; i < STATE_NUM; i++) begin
            mean_ff[i] <= '0;
         end
         for (int i = 0; i < PAIR_NUM; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         last_ff  <= last_in;
         mean_ff  <= mean_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      new_ff         <= new_in;
      dfx_ff         <= dfx_in;
      n_ff           <= n_in;
      trans_ff       <= trans_in;
      ge_ff          <= ge_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      bit_ff         <= bit_in;
      out_changed_ff <= out_changed_in;
      out_cur_ff     <= out_cur_in;
      out_left_ff    <= out_left_in;
      out_mean_ff    <= out_mean_in;
      out_visits_ff  <= out_visits_in;
      out_trans_ff   <= out_trans_in;
   end

   // A recorded transition always leaves a different state than it enters.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_changed) |-> (rsp_left_state != rsp_current_state))
      else $error("transition reported between identical states");

   // The departure count is bumped before it is reported, so it is never zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_changed) |-> ((rsp_left_visits != '0) && (rsp_transition_count != '0)))
      else $error("transition reported with a zero count");

   // An accepted transaction keeps the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !rsp_valid))
      else $error("block not busy after accepting a transaction");

   // The divider only runs on a transition, never while a result is presented.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (!rsp_valid && (n_ff != '0)))
      else $error("divider running with zero divisor or pending result");

endmodule
